@@ rtl/tsrb_pkg.sv @@
`timescale 1ns / 1ps

package tsrb_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FOCUS_CENTER = 2'd0,
    REG_BAND_HEIGHT  = 2'd1,
    REG_EDGE_DECAY   = 2'd2
  } cfg_reg_t;

  // One pixel, channels in blue, green, red order.
  typedef logic [2:0][7:0] bgr_t;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Edge divider: quotient bits and how they are spread over the stages.
  localparam int Q_BITS     = 11;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 3;

  // Largest tanh argument in Q8 (4.0) and the top table entry.
  localparam logic [10:0] Q_SAT    = 11'd1024;
  localparam logic [14:0] TANH_TOP = 15'd32746;
  localparam logic [15:0] W_ONE    = 16'd32768;

  // Control that travels alongside the two divider results.
  typedef struct packed {
    logic        valid;
    logic        neg_top;
    logic        neg_bot;
    logic [10:0] q_top;
    logic [10:0] q_bot;
  } edge_arg_t;

  // tanh(k/8) in Q15 for k = 0..32.
  function automatic logic [14:0] tanh_lut(input logic [5:0] idx);
    logic [14:0] val;
    unique case (idx)
      6'd0:  val = 15'd0;
      6'd1:  val = 15'd4075;
      6'd2:  val = 15'd8025;
      6'd3:  val = 15'd11743;
      6'd4:  val = 15'd15143;
      6'd5:  val = 15'd18173;
      6'd6:  val = 15'd20813;
      6'd7:  val = 15'd23066;
      6'd8:  val = 15'd24956;
      6'd9:  val = 15'd26519;
      6'd10: val = 15'd27797;
      6'd11: val = 15'd28830;
      6'd12: val = 15'd29660;
      6'd13: val = 15'd30322;
      6'd14: val = 15'd30847;
      6'd15: val = 15'd31262;
      6'd16: val = 15'd31589;
      6'd17: val = 15'd31846;
      6'd18: val = 15'd32048;
      6'd19: val = 15'd32206;
      6'd20: val = 15'd32329;
      6'd21: val = 15'd32426;
      6'd22: val = 15'd32501;
      6'd23: val = 15'd32560;
      6'd24: val = 15'd32606;
      6'd25: val = 15'd32642;
      6'd26: val = 15'd32670;
      6'd27: val = 15'd32691;
      6'd28: val = 15'd32708;
      6'd29: val = 15'd32721;
      6'd30: val = 15'd32732;
      6'd31: val = 15'd32740;
      default: val = TANH_TOP;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/tsrb_edge_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: q = min(floor(mag * 128 / divisor), 1024).
module tsrb_edge_div (
  input  logic        clk,
  input  logic [13:0] mag,
  input  logic [6:0]  divisor,
  output logic [10:0] q
);

  localparam int NST   = tsrb_pkg::DIV_STAGES;
  localparam int STEPS = tsrb_pkg::DIV_STEPS;
  localparam int QMSB  = tsrb_pkg::Q_BITS - 1;

  logic [6:0]  rem_q [NST];
  logic [10:0] quo_q [NST];
  logic        sat_q [NST];
  logic [3:0]  low_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [6:0]  rem_in;
    logic [10:0] quo_in;
    logic        sat_in;
    logic [3:0]  low_in;
    logic [6:0]  rem_s;
    logic [10:0] quo_s;

    if (s == 0) begin : g_first
      // A partial remainder at or above the divisor before any quotient bit
      // means a quotient of 2048 or more, which saturates anyway.
      assign rem_in = mag[10:4];
      assign sat_in = (mag[13:4] >= {3'b000, divisor});
      assign quo_in = '0;
      assign low_in = mag[3:0];
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign sat_in = sat_q[s-1];
      assign quo_in = quo_q[s-1];
      assign low_in = low_q[s-1];
    end

    always_comb begin : step
      logic [7:0]  rr;
      logic [10:0] dvd;
      int          b;
      rem_s = rem_in;
      quo_s = quo_in;
      dvd   = {low_in, 7'b0000000};
      rr    = '0;
      b     = 0;
      for (int k = 0; k < STEPS; k++) begin
        b = QMSB - STEPS * s - k;
        if (b >= 0) begin
          rr = {rem_s, dvd[4'(b)]};
          if (rr >= {1'b0, divisor}) begin
            rem_s          = 7'(rr - {1'b0, divisor});
            quo_s[4'(b)]   = 1'b1;
          end else begin
            rem_s = rr[6:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_s;
      quo_q[s] <= quo_s;
      sat_q[s] <= sat_in;
      low_q[s] <= low_in;
    end
  end

  assign q = (sat_q[NST-1] || (quo_q[NST-1] > tsrb_pkg::Q_SAT)) ? tsrb_pkg::Q_SAT
                                                                 : quo_q[NST-1];

endmodule

@@ rtl/tsrb_tanh.sv @@
`timescale 1ns / 1ps

// Table tanh with linear interpolation for both band edges, one stage.
module tsrb_tanh (
  input  logic                  clk,
  input  logic                  rst,
  input  tsrb_pkg::edge_arg_t   arg,
  output logic                  valid,
  output logic signed [15:0]    t_top,
  output logic signed [15:0]    t_bot
);

  function automatic logic [14:0] interp(input logic [10:0] q);
    logic [5:0]  idx;
    logic [4:0]  frac;
    logic [14:0] t0;
    logic [14:0] t1;
    logic [14:0] slope;
    logic [19:0] prod;
    idx   = q[10:5];
    frac  = q[4:0];
    t0    = tsrb_pkg::tanh_lut(idx);
    t1    = tsrb_pkg::tanh_lut(6'(idx + 6'd1));
    slope = (idx < 6'd32) ? 15'(t1 - t0) : 15'd0;
    prod  = {5'd0, slope} * {15'd0, frac};
    return 15'(t0 + prod[19:5]);
  endfunction

  logic [14:0] mag_top;
  logic [14:0] mag_bot;

  assign mag_top = interp(arg.q_top);
  assign mag_bot = interp(arg.q_bot);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= arg.valid;
    end
  end

  always_ff @(posedge clk) begin
    t_top <= arg.neg_top ? -$signed({1'b0, mag_top}) : $signed({1'b0, mag_top});
    t_bot <= arg.neg_bot ? -$signed({1'b0, mag_bot}) : $signed({1'b0, mag_bot});
  end

  a_tanh_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (t_top <= $signed({1'b0, tsrb_pkg::TANH_TOP}))
           && (t_top >= -$signed({1'b0, tsrb_pkg::TANH_TOP})))
    else $error("tanh of the top edge out of range");

endmodule

@@ rtl/tsrb_blend.sv @@
`timescale 1ns / 1ps

// Focus weight and per-channel blend: weight, products, sum and saturate.
module tsrb_blend (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic signed [15:0]  t_top,
  input  logic signed [15:0]  t_bot,
  input  tsrb_pkg::bgr_t      sharp,
  input  tsrb_pkg::bgr_t      blurred,
  output logic                done,
  output tsrb_pkg::bgr_t      blended
);

  logic signed [16:0] diff;
  logic [16:0]        diff_p1;
  logic [15:0]        w_next;

  logic               valid_w;
  logic [15:0]        w_q;
  tsrb_pkg::bgr_t     sharp_w;
  tsrb_pkg::bgr_t     blurred_w;

  logic               valid_p;
  logic [2:0][23:0]   prod_s;
  logic [2:0][23:0]   prod_b;

  logic [2:0][24:0]   sum;
  tsrb_pkg::bgr_t     blended_next;

  assign diff    = 17'(t_top) - 17'(t_bot);
  assign diff_p1 = 17'(diff) + 17'd1;
  assign w_next  = diff[16] ? 16'd0 : 16'(diff_p1 >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_w <= 1'b0;
      valid_p <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_w <= valid;
      valid_p <= valid_w;
      done    <= valid_p;
    end
  end

  always_ff @(posedge clk) begin
    w_q       <= w_next;
    sharp_w   <= sharp;
    blurred_w <= blurred;
    for (int c = 0; c < 3; c++) begin
      prod_s[c] <= {8'd0, w_q} * {16'd0, sharp_w[c]};
      prod_b[c] <= {8'd0, 16'(tsrb_pkg::W_ONE - w_q)} * {16'd0, blurred_w[c]};
    end
    blended <= blended_next;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = 25'(prod_s[c]) + 25'(prod_b[c]) + 25'd16384;
      blended_next[c] = (sum[c][24:15] > 10'd255) ? 8'd255 : sum[c][22:15];
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    valid_w |-> (w_q <= tsrb_pkg::W_ONE))
    else $error("focus weight above one");

endmodule

@@ rtl/tilt_shift_row_blend_top.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                       Direction  Flow control
// -------   -------------------------------------------   ---------  ------------------------
// input     start, row_index, sharp_*, blurred_*          in         taken when start & !busy
// status    busy                                          out        always low
// result    done, out_blue, out_green, out_red            out        one cycle, cannot stall
// config    cfg_valid, cfg_index, cfg_data, cfg_ready     in/out     written when valid&ready
//
// One item enters per clock; the pipeline is nine registers deep, and the
// result of an accepted item leaves the last of them onto the result ports
// with done high. Four of the registers are the band-edge divider, which
// resolves three quotient bits per stage over four stages.
// Reset is synchronous and active high; it clears the valid bits along the
// pipeline and returns the configuration to center 0, band 0, decay 1.
// Nothing stalls: busy stays low and every item yields exactly one result.
//
// Each item gets a focus weight 0.5*(tanh((row-top)/decay) - tanh((row-bottom)
// /decay)) in Q1.15, and each channel is blended as w*sharp + (1-w)*blurred,
// rounded to nearest and saturated to 0..255. The tanh arguments are worked in
// half rows so that an odd band height needs no fraction.
module tilt_shift_row_blend_top #(
  parameter int MAX_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        start,
  output logic        busy,
  input  logic [11:0] row_index,
  input  logic [7:0]  sharp_blue,
  input  logic [7:0]  sharp_green,
  input  logic [7:0]  sharp_red,
  input  logic [7:0]  blurred_blue,
  input  logic [7:0]  blurred_green,
  input  logic [7:0]  blurred_red,

  output logic        done,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int          NST       = tsrb_pkg::DIV_STAGES;
  localparam int          LATENCY   = NST + 5;
  localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS - 1);

  // Configuration registers.
  logic [11:0] focus_center_row;
  logic [11:0] band_height;
  logic [6:0]  edge_decay;
  logic [6:0]  decay_eff;

  // The block never holds off either side.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_center_row <= 12'd0;
      band_height      <= 12'd0;
      edge_decay       <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsrb_pkg::REG_FOCUS_CENTER: focus_center_row <= cfg_data;
        tsrb_pkg::REG_BAND_HEIGHT:  band_height      <= cfg_data;
        tsrb_pkg::REG_EDGE_DECAY:   edge_decay       <= cfg_data[6:0];
        default: ;  // Writes to an unused index are dropped.
      endcase
    end
  end

  // A decay of zero behaves as one.
  assign decay_eff = (edge_decay == 7'd0) ? 7'd1 : edge_decay;

  // Stage zero: clamp the row, form both edge arguments in half rows and take
  // their magnitudes. The signs travel separately and are put back after tanh.
  logic [11:0]        row_c;
  logic signed [14:0] base;
  logic signed [14:0] n_top;
  logic signed [14:0] n_bot;

  assign row_c = ({5'd0, row_index} > ROW_LIMIT) ? ROW_LIMIT[11:0] : row_index;
  assign base  = $signed({2'b00, row_c, 1'b0}) - $signed({2'b00, focus_center_row, 1'b0});
  assign n_top = base + $signed({3'b000, band_height});
  assign n_bot = base - $signed({3'b000, band_height});

  logic [13:0] mag_top;
  logic [13:0] mag_bot;

  always_ff @(posedge clk) begin
    mag_top <= n_top[14] ? 14'(-n_top) : n_top[13:0];
    mag_bot <= n_bot[14] ? 14'(-n_bot) : n_bot[13:0];
  end

  // Side lines that carry the valid bit, edge signs and pixels alongside the
  // divider. Index k is the register after index k-1.
  logic                 vld_line  [NST+1];
  logic                 ntop_line [NST+1];
  logic                 nbot_line [NST+1];
  tsrb_pkg::bgr_t       sharp_line   [NST+2];
  tsrb_pkg::bgr_t       blurred_line [NST+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NST; k++) begin
        vld_line[k] <= 1'b0;
      end
    end else begin
      vld_line[0] <= start && !busy;
      for (int k = 1; k <= NST; k++) begin
        vld_line[k] <= vld_line[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ntop_line[0]    <= n_top[14];
    nbot_line[0]    <= n_bot[14];
    sharp_line[0]   <= {sharp_red, sharp_green, sharp_blue};
    blurred_line[0] <= {blurred_red, blurred_green, blurred_blue};
    for (int k = 1; k <= NST; k++) begin
      ntop_line[k] <= ntop_line[k-1];
      nbot_line[k] <= nbot_line[k-1];
    end
    for (int k = 1; k <= NST + 1; k++) begin
      sharp_line[k]   <= sharp_line[k-1];
      blurred_line[k] <= blurred_line[k-1];
    end
  end

  // Band-edge dividers: |n| * 128 / decay, clamped to 4.0 in Q8.
  logic [10:0] q_top;
  logic [10:0] q_bot;

  tsrb_edge_div u_div_top (
    .clk     (clk),
    .mag     (mag_top),
    .divisor (decay_eff),
    .q       (q_top)
  );

  tsrb_edge_div u_div_bot (
    .clk     (clk),
    .mag     (mag_bot),
    .divisor (decay_eff),
    .q       (q_bot)
  );

  // tanh of both edges with the signs restored.
  tsrb_pkg::edge_arg_t edge_arg;
  logic                tanh_valid;
  logic signed [15:0]  t_top;
  logic signed [15:0]  t_bot;

  assign edge_arg.valid   = vld_line[NST];
  assign edge_arg.neg_top = ntop_line[NST];
  assign edge_arg.neg_bot = nbot_line[NST];
  assign edge_arg.q_top   = q_top;
  assign edge_arg.q_bot   = q_bot;

  tsrb_tanh u_tanh (
    .clk   (clk),
    .rst   (rst),
    .arg   (edge_arg),
    .valid (tanh_valid),
    .t_top (t_top),
    .t_bot (t_bot)
  );

  // Weight and blend.
  tsrb_pkg::bgr_t blended;

  tsrb_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .valid   (tanh_valid),
    .t_top   (t_top),
    .t_bot   (t_bot),
    .sharp   (sharp_line[NST+1]),
    .blurred (blurred_line[NST+1]),
    .done    (done),
    .blended (blended)
  );

  assign out_blue  = blended[tsrb_pkg::CH_BLUE];
  assign out_green = blended[tsrb_pkg::CH_GREEN];
  assign out_red   = blended[tsrb_pkg::CH_RED];

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

endmodule

@@ sim/tb_tilt_shift_row_blend_top.sv @@
`timescale 1ns / 1ps

module tb_tilt_shift_row_blend_top;
  import tsrb_pkg::*;

  // The block is nine registers deep. Wait longer than that whenever the
  // pipeline has to be empty, so that a stray late result is still caught.
  localparam int LAT_CYCLES    = 9;
  localparam int SETTLE_CYCLES = LAT_CYCLES + 4;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int REPORT_MAX    = 10;
  localparam int ROW_COUNT     = 4096;
  localparam int ITEMS_PER_SET = 67;
  localparam int SETS_PER_MODE = 7;

  // The register index space has one unused slot. Writes to it must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // tanh(k/8) in Q15 at steps of one eighth, from 0 up to 4.0.
  localparam int TANH_STEP_Q15 [33] = '{
    0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
    24956, 26519, 27797, 28830, 29660, 30322, 30847, 31262,
    31589, 31846, 32048, 32206, 32329, 32426, 32501, 32560,
    32606, 32642, 32670, 32691, 32708, 32721, 32732, 32740,
    32746
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic        busy;
  logic [11:0] row_index     = '0;
  logic [7:0]  sharp_blue    = '0;
  logic [7:0]  sharp_green   = '0;
  logic [7:0]  sharp_red     = '0;
  logic [7:0]  blurred_blue  = '0;
  logic [7:0]  blurred_green = '0;
  logic [7:0]  blurred_red   = '0;
  logic        done;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [11:0] cfg_data      = '0;

  // Shadow copy of the configuration. It holds the reset values until the
  // first write and is updated at each accepted write.
  logic [11:0] center_cfg = 12'd0;
  logic [11:0] band_cfg   = 12'd0;
  logic [6:0]  decay_cfg  = 7'd1;

  // Expected blends of accepted pixels whose results have not come back yet.
  bgr_t blend_expect_q [$];

  int idle_pct      = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int mismatch_cnt  = 0;
  int cfg_writes    = 0;
  int cycle_cnt     = 0;

  tilt_shift_row_blend_top #(
    .MAX_ROWS(ROW_COUNT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .row_index    (row_index),
    .sharp_blue   (sharp_blue),
    .sharp_green  (sharp_green),
    .sharp_red    (sharp_red),
    .blurred_blue (blurred_blue),
    .blurred_green(blurred_green),
    .blurred_red  (blurred_red),
    .done         (done),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Compute tanh(n / (2*dec)) in Q15. The argument n is counted in half rows.
  // The magnitude is scaled to Q8 and clamped at 4.0. It is then looked up and
  // interpolated with the truncated step. The sign goes back on at the end,
  // so the function is odd.
  function automatic int tanh_q15(input int n, input int dec);
    int mag, q, idx, frac, t;
    mag = (n < 0) ? -n : n;
    q = (mag * 128) / dec;
    if (q > 1024) q = 1024;
    idx = q >> 5;
    frac = q & 31;
    t = TANH_STEP_Q15[idx];
    if (idx < 32) t += ((TANH_STEP_Q15[idx + 1] - TANH_STEP_Q15[idx]) * frac) >> 5;
    return (n < 0) ? -t : t;
  endfunction

  // Compute the focus weight of the row and blend every channel with it. The
  // current shadow configuration is used.
  function automatic bgr_t predict_blend(input logic [11:0] row, input bgr_t sharp,
                                         input bgr_t blurred);
    int   dec, r, half_base, t_top, t_bot, diff, w, v;
    bgr_t res;
    dec = (decay_cfg == 7'd0) ? 1 : int'(decay_cfg);
    r = int'(row);
    if (r > ROW_COUNT - 1) r = ROW_COUNT - 1;
    half_base = 2 * r - 2 * int'(center_cfg);
    t_top = tanh_q15(half_base + int'(band_cfg), dec);
    t_bot = tanh_q15(half_base - int'(band_cfg), dec);
    diff = t_top - t_bot;
    if (diff < 0) diff = 0;
    w = (diff + 1) >> 1;
    for (int ch = 0; ch < 3; ch++) begin
      v = (w * int'(sharp[ch]) + (int'(W_ONE) - w) * int'(blurred[ch]) + 16384) >> 15;
      if (v > 255) v = 255;
      res[ch] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bgr_t rand_pixel();
    bgr_t px;
    for (int ch = 0; ch < 3; ch++) px[ch] = rand_chan();
    return px;
  endfunction

  // Most rows fall within a few decay lengths of a band edge, where the
  // weight actually moves. The rest are spread over the whole image.
  function automatic logic [11:0] pick_row();
    int d, half_band, r;
    d = (decay_cfg == 7'd0) ? 1 : int'(decay_cfg);
    half_band = int'(band_cfg) / 2;
    if ($urandom_range(3) == 0) return 12'($urandom_range(ROW_COUNT - 1));
    r = int'(center_cfg) + ($urandom_range(1) ? half_band : -half_band);
    r = r + int'($urandom_range(8 * d)) - 4 * d;
    if (r < 0) r = 0;
    if (r > ROW_COUNT - 1) r = ROW_COUNT - 1;
    return 12'(r);
  endfunction

  // Offer one pixel item, with an optional random gap first. This is called
  // and returns at a falling edge. start is left high, so that back-to-back
  // items need no second assignment in the same step.
  task automatic send_pixel(input logic [11:0] row, input bgr_t sharp, input bgr_t blurred);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    row_index     <= row;
    sharp_blue    <= sharp[CH_BLUE];
    sharp_green   <= sharp[CH_GREEN];
    sharp_red     <= sharp[CH_RED];
    blurred_blue  <= blurred[CH_BLUE];
    blurred_green <= blurred[CH_GREEN];
    blurred_red   <= blurred[CH_RED];
    do @(posedge clk); while (busy);
    blend_expect_q.push_back(predict_blend(row, sharp, blurred));
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering items and wait until every expected blend has come back.
  // Then let the pipeline run empty. This ends at a falling edge.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (blend_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register. cfg_valid is left high. The caller lowers it once
  // the burst of writes is done.
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCUS_CENTER: center_cfg = data;
      REG_BAND_HEIGHT:  band_cfg   = data;
      REG_EDGE_DECAY:   decay_cfg  = data[6:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [11:0] center, input logic [11:0] band,
                               input logic [11:0] decay_data);
    drain_pipeline();
    write_reg(REG_FOCUS_CENTER, center);
    write_reg(REG_BAND_HEIGHT, band);
    write_reg(REG_EDGE_DECAY, decay_data);
    cfg_valid <= 1'b0;
  endtask

  // With the reset configuration the band is empty. Every pixel then comes
  // out as its blurred value.
  task automatic test_reset_defaults();
    send_pixel(12'd0, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd4095, {3{8'd0}}, {3{8'd255}});
    send_pixel(12'd1, {8'hA5, 8'h5A, 8'hFF}, {8'h5A, 8'hA5, 8'h00});
    drain_pipeline();
  endtask

  // The widest band with the sharpest edges gives the largest weight. A
  // one-row band with the softest decay in range keeps the weight small
  // everywhere.
  task automatic test_blend_extremes();
    apply_setting(12'd2048, 12'd4095, 12'd1);
    send_pixel(12'd2048, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd0, {3{8'd0}}, {3{8'd255}});
    send_pixel(12'd4095, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1024, {8'd255, 8'd0, 8'd128}, {8'd0, 8'd255, 8'd127});
    apply_setting(12'd1000, 12'd1, 12'd100);
    send_pixel(12'd1000, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd999, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1001, {3{8'd0}}, {3{8'd255}});
    send_pixel(12'd0, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd4095, {3{8'd255}}, {3{8'd0}});
  endtask

  // A decay that masks to zero must act as a decay of one. The data carries
  // set upper bits, which the 7-bit register drops. Decay 127 is past the
  // usual range, but the field allows it.
  task automatic test_decay_corner();
    apply_setting(12'd1000, 12'd200, 12'hF80);
    send_pixel(12'd900, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd899, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1100, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1101, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1000, {3{8'd255}}, {3{8'd0}});
    apply_setting(12'd1000, 12'd200, 12'h07F);
    send_pixel(12'd900, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd1000, {3{8'd200}}, {3{8'd17}});
    send_pixel(12'd0, {3{8'd255}}, {3{8'd0}});
  endtask

  // A write to the unused index must leave all three registers alone.
  task automatic test_spare_register();
    apply_setting(12'd500, 12'd100, 12'd10);
    @(negedge clk);
    write_reg(REG_SPARE, 12'hFFF);
    cfg_valid <= 1'b0;
    send_pixel(12'd450, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd500, {3{8'd255}}, {3{8'd0}});
    send_pixel(12'd550, {3{8'd255}}, {3{8'd0}});
  endtask

  // Random pixels run under three levels of sender idling. Within each level,
  // the first two settings are extremes, the third sets every decay bit, the rest are random.
  task automatic test_random_blend();
    int          idle_sched [3] = '{16, 56, 0};
    logic [11:0] c, b, d;
    for (int m = 0; m < 3; m++) begin
      for (int s = 0; s < SETS_PER_MODE; s++) begin
        case (s)
          0: begin
            c = 12'd0;    b = 12'd0;    d = 12'd1;
          end
          1: begin
            c = 12'd4095; b = 12'd4095; d = 12'd100;
          end
          2: begin
            c = 12'($urandom_range(4095)); b = 12'($urandom_range(600)); d = 12'hFFF;
          end
          default: begin
            c = 12'($urandom_range(4095));
            b = $urandom_range(1) ? 12'($urandom_range(400)) : 12'($urandom_range(4095));
            d = 12'($urandom_range(1, 100));
            if ($urandom_range(3) == 0) d[11:7] = 5'($urandom_range(31));
          end
        endcase
        apply_setting(c, b, d);
        idle_pct = idle_sched[m];
        for (int k = 0; k < ITEMS_PER_SET; k++) send_pixel(pick_row(), rand_pixel(), rand_pixel());
      end
    end
    idle_pct = 0;
  endtask

  // Result checker. A result is on the ports for exactly one cycle. It is
  // taken at the rising edge that closes that cycle and matched with the
  // oldest pixel still waiting.
  always @(posedge clk) begin
    bgr_t got, want;
    if (!rst && done) begin
      got[CH_BLUE]  = out_blue;
      got[CH_GREEN] = out_green;
      got[CH_RED]   = out_red;
      if (blend_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("cycle %0d: unexpected result b=%0d g=%0d r=%0d",
                   cycle_cnt, got[CH_BLUE], got[CH_GREEN], got[CH_RED]);
      end else begin
        want = blend_expect_q.pop_front();
        results_seen++;
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("cycle %0d: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     cycle_cnt, want[CH_BLUE], want[CH_GREEN], want[CH_RED],
                     got[CH_BLUE], got[CH_GREEN], got[CH_RED]);
        end
      end
    end
  end

  // This watchdog catches a block that stops producing results.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, blend_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int leftover;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_blend_extremes();
    test_decay_corner();
    test_spare_register();
    test_random_blend();
    drain_pipeline();

    leftover = blend_expect_q.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("Blended %0d pixel items over %0d register writes at three idle levels.",
             items_sent, cfg_writes);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && leftover == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
